[hdl/i2cm_pkg.sv]
package i2cm_pkg;

  localparam int TICK_W  = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [4:0] LAST_START = 5'd3;
  localparam logic [4:0] LAST_STOP  = 5'd2;
  localparam logic [4:0] LAST_WRITE = 5'd17;
  localparam logic [4:0] LAST_READ  = 5'd19;

  localparam logic [4:0] PH_ACK_DRIVE = 5'd16;
  localparam logic [4:0] PH_ACK_HIGH  = 5'd17;
  localparam logic [4:0] PH_ACK_LOW   = 5'd18;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = TICK_W'(250);

  typedef struct packed {
    logic       is_cmd;
    logic [2:0] op;
    logic [7:0] wbyte;
    logic       ackr;
    logic       sda;
  } q_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       nack;
    logic       rej;
  } res_t;

endpackage

[hdl/i2cm_front.sv]
module i2cm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          op,
  input  logic [7:0]          write_byte,
  input  logic                ack_release,
  input  logic                sda_in,
  output logic                q_valid,
  output i2cm_pkg::q_item_t   q_item,
  input  logic                q_pop
);

  i2cm_pkg::q_item_t              entry [i2cm_pkg::Q_DEPTH];
  logic [i2cm_pkg::Q_AW-1:0]      wr_ptr;
  logic [i2cm_pkg::Q_AW-1:0]      rd_ptr;
  logic [i2cm_pkg::Q_AW:0]        count;
  i2cm_pkg::q_item_t              item;
  logic                           push;
  logic                           pop;

  always_comb begin
    item.is_cmd = (op >= i2cm_pkg::CMD_START) && (op <= i2cm_pkg::CMD_READ);
    item.op     = op;
    item.wbyte  = write_byte;
    item.ackr   = ack_release;
    item.sda    = sda_in;
  end

  assign in_stall = (count == (i2cm_pkg::Q_AW+1)'(i2cm_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (i2cm_pkg::Q_AW+1)'(i2cm_pkg::Q_DEPTH)) else $error("queue overfill");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[i2cm_pkg::Q_AW-1:0]) else $error("queue pointers out of step");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1) else $error("pop lost");

endmodule

[hdl/i2cm_back.sv]
module i2cm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  i2cm_pkg::q_item_t          q_item,
  output logic                       q_pop,
  input  logic                       cfg_we,
  input  logic [i2cm_pkg::TICK_W-1:0] cfg_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output i2cm_pkg::res_t             res
);

  logic [i2cm_pkg::TICK_W-1:0] phase_ticks;
  logic [2:0]                  cmd, cmd_next;
  logic [4:0]                  phase, phase_next;
  logic [i2cm_pkg::TICK_W-1:0] wait_cnt, wait_cnt_next;
  logic [7:0]                  shift, shift_next;
  logic                        ack_choice, ack_choice_next;
  logic [1:0]                  line, line_next;
  logic                        last_ack, last_ack_next;
  logic [7:0]                  rx_held, rx_held_next;
  logic [i2cm_pkg::TICK_W-1:0] eff;
  logic [i2cm_pkg::TICK_W:0]   wait_inc;
  logic [4:0]                  last_ph;
  logic                        ep_en;
  logic [4:0]                  ep_p;
  logic                        rej;
  logic                        done;
  logic                        take;
  i2cm_pkg::res_t              res_next;

  assign eff   = (phase_ticks == '0) ? i2cm_pkg::TICK_W'(1) : phase_ticks;
  assign take  = q_valid && (!out_valid || !out_stall);
  assign q_pop = take;

  always_comb begin
    case (cmd)
      i2cm_pkg::CMD_START: last_ph = i2cm_pkg::LAST_START;
      i2cm_pkg::CMD_STOP:  last_ph = i2cm_pkg::LAST_STOP;
      i2cm_pkg::CMD_WRITE: last_ph = i2cm_pkg::LAST_WRITE;
      default:             last_ph = i2cm_pkg::LAST_READ;
    endcase
  end

  always_comb begin
    cmd_next        = cmd;
    phase_next      = phase;
    wait_cnt_next   = wait_cnt;
    shift_next      = shift;
    ack_choice_next = ack_choice;
    line_next       = line;
    last_ack_next   = last_ack;
    rx_held_next    = rx_held;
    rej             = 1'b0;
    done            = 1'b0;
    ep_en           = 1'b0;
    ep_p            = '0;
    wait_inc        = {1'b0, wait_cnt} + 1'b1;

    if (cmd != i2cm_pkg::CMD_NONE) begin
      rej = q_item.is_cmd;
      if (wait_inc >= {1'b0, eff}) begin
        wait_cnt_next = '0;
        if (cmd == i2cm_pkg::CMD_READ && phase < 5'd16 && !phase[0]) begin
          shift_next = {shift[6:0], q_item.sda};
        end
        if (cmd == i2cm_pkg::CMD_WRITE && phase == i2cm_pkg::PH_ACK_HIGH) begin
          last_ack_next = q_item.sda;
        end
        if (phase >= last_ph) begin
          if (cmd == i2cm_pkg::CMD_WRITE) line_next = 2'b00;
          if (cmd == i2cm_pkg::CMD_READ)  rx_held_next = shift_next;
          cmd_next   = i2cm_pkg::CMD_NONE;
          phase_next = '0;
          done       = 1'b1;
        end else begin
          ep_en = 1'b1;
          ep_p  = phase + 1'b1;
        end
      end else begin
        wait_cnt_next = wait_inc[i2cm_pkg::TICK_W-1:0];
      end
    end else if (q_item.is_cmd) begin
      cmd_next      = q_item.op;
      wait_cnt_next = '0;
      if (q_item.op == i2cm_pkg::CMD_WRITE) begin
        shift_next = q_item.wbyte;
      end else if (q_item.op == i2cm_pkg::CMD_READ) begin
        shift_next      = '0;
        ack_choice_next = q_item.ackr;
      end
      ep_en = 1'b1;
      ep_p  = '0;
    end

    if (ep_en) begin
      phase_next = ep_p;
      case (cmd_next)
        i2cm_pkg::CMD_START: begin
          if (ep_p == 5'd0)      line_next[1] = 1'b1;
          else if (ep_p == 5'd1) line_next[0] = 1'b1;
          else if (ep_p == 5'd2) line_next[1] = 1'b0;
          else                   line_next[0] = 1'b0;
        end
        i2cm_pkg::CMD_STOP: begin
          if (ep_p == 5'd0)      line_next[1] = 1'b0;
          else if (ep_p == 5'd1) line_next[0] = 1'b1;
          else                   line_next[1] = 1'b1;
        end
        i2cm_pkg::CMD_WRITE: begin
          if (ep_p < 5'd16) begin
            if (!ep_p[0]) begin
              line_next[1] = shift_next[7];
              line_next[0] = 1'b1;
            end else begin
              shift_next   = {shift_next[6:0], 1'b0};
              line_next[0] = 1'b0;
            end
          end else if (ep_p == i2cm_pkg::PH_ACK_DRIVE) begin
            line_next[1] = 1'b1;
          end else begin
            line_next[0] = 1'b1;
          end
        end
        default: begin
          if (ep_p < 5'd16) begin
            if (!ep_p[0]) line_next = 2'b11;
            else          line_next[0] = 1'b0;
          end else if (ep_p == i2cm_pkg::PH_ACK_DRIVE) begin
            line_next[1] = ack_choice_next;
          end else if (ep_p == i2cm_pkg::PH_ACK_HIGH) begin
            line_next[0] = 1'b1;
          end else if (ep_p == i2cm_pkg::PH_ACK_LOW) begin
            line_next[0] = 1'b0;
          end else begin
            line_next[1] = 1'b1;
          end
        end
      endcase
    end

    res_next.scl  = line_next[0];
    res_next.sda  = line_next[1];
    res_next.busy = (cmd_next != i2cm_pkg::CMD_NONE);
    res_next.done = done;
    res_next.rx   = rx_held_next;
    res_next.nack = last_ack_next;
    res_next.rej  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
      cmd         <= i2cm_pkg::CMD_NONE;
      phase       <= '0;
      wait_cnt    <= '0;
      shift       <= '0;
      ack_choice  <= 1'b1;
      line        <= 2'b11;
      last_ack    <= 1'b0;
      rx_held     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) phase_ticks <= cfg_data;
      if (take) begin
        cmd        <= cmd_next;
        phase      <= phase_next;
        wait_cnt   <= wait_cnt_next;
        shift      <= shift_next;
        ack_choice <= ack_choice_next;
        line       <= line_next;
        last_ack   <= last_ack_next;
        rx_held    <= rx_held_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    cmd == i2cm_pkg::CMD_NONE |-> phase == '0 && wait_cnt == '0)
    else $error("idle with phase state left over");
  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    cmd != i2cm_pkg::CMD_NONE |-> wait_cnt != '1 && phase <= i2cm_pkg::LAST_READ)
    else $error("sequencer counters out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(cmd) && $stable(phase) && $stable(line))
    else $error("sequencer moved without a transaction");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    take && done |=> cmd == i2cm_pkg::CMD_NONE && !res.busy)
    else $error("done while still busy");

endmodule

[hdl/i2c_master_bit_engine_core.sv]
// Path: an input transaction reaches the earliest output transaction through the input queue
//   and then the back end's result register; an output stall can hold it in the queue.
// Throughput: one tick per cycle while a tick waits and the output register is free; the
//   back-end sequencer is fed from a 4-entry input queue and drained by one output register.
// Reset (rst, synchronous): queue emptied, internal line state released, sequencer idle,
//   phase_ticks back to 250; the result register is not reset; no clearing pass.
module i2c_master_bit_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [7:0]  write_byte,
  input  logic        ack_release,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_release,
  output logic        sda_release,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_byte,
  output logic        nack_seen,
  output logic        rejected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic              q_valid;
  logic              q_pop;
  i2cm_pkg::q_item_t q_item;
  i2cm_pkg::res_t    res;

  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .write_byte  (write_byte),
    .ack_release (ack_release),
    .sda_in      (sda_in),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign scl_release = res.scl;
  assign sda_release = res.sda;
  assign busy_res    = res.busy;
  assign done_res    = res.done;
  assign read_byte   = res.rx;
  assign nack_seen   = res.nack;
  assign rejected    = res.rej;

endmodule
